/* hw/rtl/mepcs_pkg.sv */
// ----------------------------------------------------------------------------
// mepcs_pkg: shared types and constants of the effect parameter change sender
// Holds the request and message structs, the per-track record layout and the
// controller numbers of the eight effect parameters.
// ----------------------------------------------------------------------------
package mepcs_pkg;

    localparam int TRACK_COUNT = 16;
    localparam int TRACK_AW    = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
    localparam int PARAM_COUNT = 8;
    localparam int PARAM_IW    = 3;

    localparam logic [7:0] NEVER_SENT      = 8'd128;
    localparam logic [3:0] BUS_NIBBLE      = 4'hF;
    localparam logic [3:0] STATUS_PRESSURE = 4'hA;
    localparam logic [3:0] STATUS_CONTROL  = 4'hB;

    // Parameter slots, in sending order.
    localparam logic [PARAM_IW-1:0] P_MODE     = 3'd0;
    localparam logic [PARAM_IW-1:0] P_SHAPE    = 3'd1;
    localparam logic [PARAM_IW-1:0] P_CLOCK    = 3'd2;
    localparam logic [PARAM_IW-1:0] P_COLOR    = 3'd3;
    localparam logic [PARAM_IW-1:0] P_FEEDBACK = 3'd4;
    localparam logic [PARAM_IW-1:0] P_DEPTH    = 3'd5;
    localparam logic [PARAM_IW-1:0] P_RATE     = 3'd6;
    localparam logic [PARAM_IW-1:0] P_DELAY    = 3'd7;

    localparam logic [6:0] CC_MODE     = 7'h70;
    localparam logic [6:0] CC_SHAPE    = 7'h76;
    localparam logic [6:0] KEY_CLOCK   = 7'h14;
    localparam logic [6:0] CC_COLOR    = 7'h77;
    localparam logic [6:0] CC_FEEDBACK = 7'h73;
    localparam logic [6:0] CC_DEPTH    = 7'h75;
    localparam logic [6:0] CC_RATE     = 7'h74;
    localparam logic [6:0] CC_DELAY    = 7'h72;

    typedef struct packed {
        logic [3:0] track_index;
        logic       track_active;
        logic [7:0] out_port;
        logic [3:0] out_channel;
        logic [6:0] mode_value;
        logic [6:0] shape_value;
        logic [6:0] clock_value;
        logic [6:0] color_value;
        logic [6:0] feedback_value;
        logic [6:0] depth_value;
        logic [6:0] rate_value;
        logic [6:0] delay_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [6:0] controller_number;
        logic [6:0] data_value;
        logic [7:0] dest_port;
        logic       to_bus;
        logic       last_of_run;
    } out_item_t;

    // One memory row holds everything remembered about a track.
    typedef struct packed {
        logic [7:0]                  port;
        logic [3:0]                  channel;
        logic [PARAM_COUNT-1:0][7:0] values;
    } row_t;

    localparam row_t RESET_ROW = '{
        port:    8'd0,
        channel: 4'd0,
        values:  {PARAM_COUNT{NEVER_SENT}}
    };

    function automatic logic [6:0] param_code(input logic [PARAM_IW-1:0] idx);
        logic [6:0] code;
        unique case (idx)
            P_MODE:     code = CC_MODE;
            P_SHAPE:    code = CC_SHAPE;
            P_CLOCK:    code = KEY_CLOCK;
            P_COLOR:    code = CC_COLOR;
            P_FEEDBACK: code = CC_FEEDBACK;
            P_DEPTH:    code = CC_DEPTH;
            P_RATE:     code = CC_RATE;
            P_DELAY:    code = CC_DELAY;
            default:    code = CC_MODE;
        endcase
        return code;
    endfunction

    function automatic logic [6:0] param_value(input in_item_t item,
                                               input logic [PARAM_IW-1:0] idx);
        logic [6:0] v;
        unique case (idx)
            P_MODE:     v = item.mode_value;
            P_SHAPE:    v = item.shape_value;
            P_CLOCK:    v = item.clock_value;
            P_COLOR:    v = item.color_value;
            P_FEEDBACK: v = item.feedback_value;
            P_DEPTH:    v = item.depth_value;
            P_RATE:     v = item.rate_value;
            P_DELAY:    v = item.delay_value;
            default:    v = item.mode_value;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/mepcs_row_ram.sv */
// ----------------------------------------------------------------------------
// mepcs_row_ram: per-track record memory
// One write port and one read port; read data is registered, so it appears
// in the cycle after the read is issued.
// ----------------------------------------------------------------------------
module mepcs_row_ram (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [mepcs_pkg::TRACK_AW-1:0] wr_addr,
    input  mepcs_pkg::row_t                wr_data,
    input  logic                           rd_en,
    input  logic [mepcs_pkg::TRACK_AW-1:0] rd_addr,
    output mepcs_pkg::row_t                rd_data
);

    mepcs_pkg::row_t mem [mepcs_pkg::TRACK_COUNT];
    mepcs_pkg::row_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/mepcs_msg_fmt.sv */
// ----------------------------------------------------------------------------
// mepcs_msg_fmt: message picker and formatter
// Picks the first pending parameter in sending order, builds its three-byte
// message and returns the set of parameters still pending after it.
// ----------------------------------------------------------------------------
module mepcs_msg_fmt (
    input  logic [mepcs_pkg::PARAM_COUNT-1:0] pending,
    input  mepcs_pkg::in_item_t               item,
    output mepcs_pkg::out_item_t              msg,
    output logic [mepcs_pkg::PARAM_COUNT-1:0] pending_rest
);

    logic [mepcs_pkg::PARAM_IW-1:0]    sel;
    logic [mepcs_pkg::PARAM_COUNT-1:0] rest;

    always_comb begin
        sel = '0;
        // Walk downwards so that the lowest pending slot wins.
        for (int i = mepcs_pkg::PARAM_COUNT - 1; i >= 0; i--) begin
            if (pending[i]) begin
                sel = mepcs_pkg::PARAM_IW'(i);
            end
        end

        rest      = pending;
        rest[sel] = 1'b0;

        msg.status_byte = {(sel == mepcs_pkg::P_CLOCK) ? mepcs_pkg::STATUS_PRESSURE
                                                       : mepcs_pkg::STATUS_CONTROL,
                           item.out_channel};
        msg.controller_number = mepcs_pkg::param_code(sel);
        msg.data_value        = mepcs_pkg::param_value(item, sel);
        msg.dest_port         = item.out_port;
        msg.to_bus            = (item.out_port[7:4] == mepcs_pkg::BUS_NIBBLE);
        msg.last_of_run       = (rest == '0);
    end

    assign pending_rest = rest;

endmodule

/* hw/rtl/midi_effect_param_change_sender.sv */
// ----------------------------------------------------------------------------
// midi_effect_param_change_sender: effect parameter change sender
// Compares an update request against the stored record of its track, writes
// the record back and emits one MIDI message per changed parameter.
// ----------------------------------------------------------------------------
// Flow: an accepted request is compared in the update state, where the record
// is written back if any value changed; its messages (0 to 8) are then sent
// from the emit state, one message per cycle while m_ready is high. No new
// request is taken until the run is done; an inactive request is dropped on
// acceptance. Reset clears the per-track valid flags at once; there is no
// clearing pass.
// ----------------------------------------------------------------------------
module midi_effect_param_change_sender (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mepcs_pkg::in_item_t   s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mepcs_pkg::out_item_t  m_item
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    state_t                            state_reg, state_next;
    mepcs_pkg::in_item_t               item_reg, item_next;
    logic [mepcs_pkg::PARAM_COUNT-1:0] pending_reg, pending_next;
    logic [mepcs_pkg::TRACK_COUNT-1:0] row_valid_reg, row_valid_next;
    logic                              row_hit_reg, row_hit_next;
    logic                              m_valid_reg, m_valid_next;
    mepcs_pkg::out_item_t              m_item_reg, m_item_next;

    logic                              s_xfer;
    logic                              req_live;
    logic [mepcs_pkg::TRACK_AW-1:0]    s_addr;
    logic [mepcs_pkg::TRACK_AW-1:0]    cur_addr;
    mepcs_pkg::row_t                   rd_data;
    mepcs_pkg::row_t                   stored_row;
    mepcs_pkg::row_t                   new_row;
    logic                              forget;
    logic [mepcs_pkg::PARAM_COUNT-1:0] changed;
    logic                              wr_en;
    logic                              out_free;
    mepcs_pkg::out_item_t              fmt_msg;
    logic [mepcs_pkg::PARAM_COUNT-1:0] fmt_rest;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign s_addr   = mepcs_pkg::TRACK_AW'(s_item.track_index);
    assign cur_addr = mepcs_pkg::TRACK_AW'(item_reg.track_index);
    assign req_live = s_item.track_active
                      && (32'(s_item.track_index) < mepcs_pkg::TRACK_COUNT);
    assign out_free = !m_valid_reg || m_ready;

    mepcs_row_ram u_row_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (cur_addr),
        .wr_data (new_row),
        .rd_en   (s_xfer),
        .rd_addr (s_addr),
        .rd_data (rd_data)
    );

    mepcs_msg_fmt u_msg_fmt (
        .pending      (pending_reg),
        .item         (item_reg),
        .msg          (fmt_msg),
        .pending_rest (fmt_rest)
    );

    // Compare the stored record with the request and build the new record.
    always_comb begin
        stored_row = row_hit_reg ? rd_data : mepcs_pkg::RESET_ROW;
        forget     = (stored_row.port != item_reg.out_port)
                     || (stored_row.channel != item_reg.out_channel);
        new_row.port    = item_reg.out_port;
        new_row.channel = item_reg.out_channel;
        for (int i = 0; i < mepcs_pkg::PARAM_COUNT; i++) begin
            new_row.values[i] = {1'b0, mepcs_pkg::param_value(item_reg,
                                                              mepcs_pkg::PARAM_IW'(i))};
            changed[i] = (forget ? mepcs_pkg::NEVER_SENT : stored_row.values[i])
                         != new_row.values[i];
        end
    end

    assign wr_en = (state_reg == ST_UPDATE) && (changed != '0);

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        pending_next   = pending_reg;
        row_valid_next = row_valid_reg;
        row_hit_next   = row_hit_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_item_next    = m_item_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer && req_live) begin
                    item_next    = s_item;
                    row_hit_next = row_valid_reg[s_addr];
                    state_next   = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                pending_next = changed;
                if (wr_en) begin
                    row_valid_next[cur_addr] = 1'b1;
                    state_next               = ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_item_next  = fmt_msg;
                    pending_next = fmt_rest;
                    if (fmt_rest == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        item_reg    <= item_next;
        pending_reg <= pending_next;
        row_hit_reg <= row_hit_next;
        m_item_reg  <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

`ifndef SYNTHESIS
    // A run is only entered with at least one message to send.
    a_emit_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (pending_reg != '0))
        else $error("emit state with nothing pending");

    // The record is written back only while a request is being compared.
    a_write_in_update: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == ST_UPDATE))
        else $error("record write outside the update cycle");

    // The message marked last ends the run and frees the block.
    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT) && out_free && fmt_msg.last_of_run)
        |=> (state_reg == ST_IDLE) && m_valid_reg && m_item_reg.last_of_run)
        else $error("last message did not end the run");

    // A live request always reaches the compare cycle next.
    a_accept_to_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && req_live) |=> (state_reg == ST_UPDATE))
        else $error("accepted request skipped the compare");
`endif

endmodule

/* bench/midi_effect_param_change_sender_tb.sv */
// ----------------------------------------------------------------------------
// midi_effect_param_change_sender_tb: self-checking bench for the sender
// Drives update requests with valid/ready, predicts the MIDI messages from a
// per-track record kept in the bench and checks every message field by field.
// ----------------------------------------------------------------------------
module midi_effect_param_change_sender_tb;

    localparam int RANDOM_REQUESTS = 130;
    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int MAX_PRINTED     = 40;
    localparam int IN_W            = $bits(mepcs_pkg::in_item_t);

    // Controller or key number of each parameter slot, in sending order.
    localparam logic [6:0] PARAM_CODES [mepcs_pkg::PARAM_COUNT] = '{
        mepcs_pkg::CC_MODE, mepcs_pkg::CC_SHAPE, mepcs_pkg::KEY_CLOCK, mepcs_pkg::CC_COLOR,
        mepcs_pkg::CC_FEEDBACK, mepcs_pkg::CC_DEPTH, mepcs_pkg::CC_RATE, mepcs_pkg::CC_DELAY
    };

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    mepcs_pkg::in_item_t  s_item  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    mepcs_pkg::out_item_t m_item;

    int cycle_count   = 0;
    int mismatches    = 0;
    int idle_cycles   = 0;
    int msgs_checked  = 0;
    int bus_msgs      = 0;
    int pressure_msgs = 0;
    int inactive_seen = 0;
    int active_seen   = 0;

    always #1 aclk = ~aclk;

    midi_effect_param_change_sender dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    class param_change_board;
        logic [7:0] stored_values [mepcs_pkg::TRACK_COUNT][mepcs_pkg::PARAM_COUNT];
        logic [7:0] stored_port [mepcs_pkg::TRACK_COUNT];
        logic [3:0] stored_channel [mepcs_pkg::TRACK_COUNT];
        mepcs_pkg::out_item_t pending_msgs [$];

        function new();
            for (int t = 0; t < mepcs_pkg::TRACK_COUNT; t++) begin
                stored_port[t]    = '0;
                stored_channel[t] = '0;
                for (int i = 0; i < mepcs_pkg::PARAM_COUNT; i++)
                    stored_values[t][i] = mepcs_pkg::NEVER_SENT;
            end
        endfunction

        function void forget_values(int trk);
            for (int i = 0; i < mepcs_pkg::PARAM_COUNT; i++)
                stored_values[trk][i] = mepcs_pkg::NEVER_SENT;
        endfunction

        // Works out the messages one accepted request causes and updates the record.
        function void note_request(mepcs_pkg::in_item_t req);
            int                   trk;
            int                   count;
            logic [55:0]          vals;
            logic [6:0]           v;
            mepcs_pkg::out_item_t msg;
            if (!req.track_active || req.track_index >= mepcs_pkg::TRACK_COUNT) return;
            trk = req.track_index;
            if (stored_port[trk] != req.out_port) begin
                stored_port[trk] = req.out_port;
                forget_values(trk);
            end
            if (stored_channel[trk] != req.out_channel) begin
                stored_channel[trk] = req.out_channel;
                forget_values(trk);
            end
            vals = {req.mode_value, req.shape_value, req.clock_value, req.color_value,
                    req.feedback_value, req.depth_value, req.rate_value, req.delay_value};
            count = 0;
            for (int i = 0; i < mepcs_pkg::PARAM_COUNT; i++) begin
                v = vals[55 - 7 * i -: 7];
                if (stored_values[trk][i] != {1'b0, v}) begin
                    stored_values[trk][i] = {1'b0, v};
                    msg.status_byte = {(i == mepcs_pkg::P_CLOCK) ? mepcs_pkg::STATUS_PRESSURE
                                                                 : mepcs_pkg::STATUS_CONTROL,
                                       req.out_channel};
                    msg.controller_number = PARAM_CODES[i];
                    msg.data_value        = v;
                    msg.dest_port         = req.out_port;
                    msg.to_bus            = (req.out_port[7:4] == mepcs_pkg::BUS_NIBBLE);
                    msg.last_of_run       = 1'b0;
                    pending_msgs.push_back(msg);
                    count++;
                end
            end
            if (count > 0) pending_msgs[pending_msgs.size() - 1].last_of_run = 1'b1;
        endfunction

        // Returns an empty string when the message matches the oldest expectation.
        function string check_message(mepcs_pkg::out_item_t got);
            mepcs_pkg::out_item_t want;
            string                diffs;
            if (pending_msgs.size() == 0)
                return $sformatf("message with nothing pending: status %02h code %02h data %02h",
                                 got.status_byte, got.controller_number, got.data_value);
            want  = pending_msgs.pop_front();
            diffs = "";
            if (got.status_byte != want.status_byte)
                diffs = {diffs, $sformatf(" status %02h/%02h", got.status_byte, want.status_byte)};
            if (got.controller_number != want.controller_number)
                diffs = {diffs, $sformatf(" code %02h/%02h", got.controller_number,
                                          want.controller_number)};
            if (got.data_value != want.data_value)
                diffs = {diffs, $sformatf(" data %02h/%02h", got.data_value, want.data_value)};
            if (got.dest_port != want.dest_port)
                diffs = {diffs, $sformatf(" port %02h/%02h", got.dest_port, want.dest_port)};
            if (got.to_bus != want.to_bus)
                diffs = {diffs, $sformatf(" bus %0b/%0b", got.to_bus, want.to_bus)};
            if (got.last_of_run != want.last_of_run)
                diffs = {diffs, $sformatf(" last %0b/%0b", got.last_of_run, want.last_of_run)};
            if (diffs != "") return {"field mismatch (got/want):", diffs};
            return "";
        endfunction
    endclass

    param_change_board board = new();

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED) $display("MISMATCH cycle %0d: %s", cycle_count, what);
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic mepcs_pkg::in_item_t make_req(logic [3:0] trk, logic act,
                                                     logic [7:0] port, logic [3:0] chn,
                                                     logic [55:0] vals);
        return {trk, act, port, chn, vals};
    endfunction

    // Valid is only lowered for a gap before the request, so back-to-back transfers keep it high.
    task automatic send_request(input mepcs_pkg::in_item_t req, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    always @(posedge aclk) begin
        string verdict;
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (s_item.track_active) active_seen++;
                else inactive_seen++;
                board.note_request(s_item);
            end
            if (m_valid && m_ready) begin
                msgs_checked++;
                if (m_item.to_bus) bus_msgs++;
                if (m_item.status_byte[7:4] == mepcs_pkg::STATUS_PRESSURE) pressure_msgs++;
                verdict = board.check_message(m_item);
                if (verdict != "") report_mismatch(verdict);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Result side: bursts of readiness broken by stalls of random length.
    initial begin
        int burst;
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            m_ready <= 1'b1;
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
            repeat (burst) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    initial begin
        mepcs_pkg::in_item_t recent [mepcs_pkg::TRACK_COUNT];
        mepcs_pkg::in_item_t req;
        logic [55:0]         vals;
        int                  sent;
        int                  calm_left;
        int                  roll;
        int                  trk;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Port 0 and channel 0 match the reset record, so the
        // first request sends all eight values, which were never sent.
        send_request(make_req(4'd0, 1'b1, 8'h00, 4'h0, {8{7'h00}}), 0);
        send_request(make_req(4'd0, 1'b1, 8'h00, 4'h0, {8{7'h00}}), 1);
        send_request(make_req(4'd0, 1'b0, 8'hAB, 4'h5, {8{7'h7F}}), 0);
        send_request(make_req(4'd0, 1'b1, 8'h00, 4'h0, {8{7'h7F}}), 2);
        vals = {{2{7'h7F}}, 7'h55, {5{7'h7F}}};
        send_request(make_req(4'd0, 1'b1, 8'h00, 4'h0, vals), 0);
        send_request(make_req(4'd0, 1'b1, 8'hF5, 4'h0, vals), 0);
        send_request(make_req(4'd0, 1'b1, 8'hF5, 4'hF, vals), 3);
        vals = {7'h2A, 7'h55, 7'h00, 7'h7F, 7'h01, 7'h40, 7'h3F, 7'h7E};
        send_request(make_req(4'd15, 1'b1, 8'hFF, 4'hF, vals), 0);
        send_request(make_req(4'd15, 1'b1, 8'hEF, 4'hF, vals), 0);
        send_request(make_req(4'd15, 1'b1, 8'h00, 4'h0, vals), 5);
        // Walk a single change through every parameter slot in turn.
        vals = {8{7'h10}};
        send_request(make_req(4'd3, 1'b1, 8'h21, 4'h9, vals), 0);
        for (int i = 0; i < mepcs_pkg::PARAM_COUNT; i++) begin
            vals[55 - 7 * i -: 7] = 7'h6B;
            send_request(make_req(4'd3, 1'b1, 8'h21, 4'h9, vals), i % 3);
        end
        send_request(make_req(4'd3, 1'b1, 8'hF0, 4'h3, vals), 0);

        // Random part: mostly well-formed updates that keep each track's port and
        // channel and change a few values, plus routing changes and inactive noise.
        for (int t = 0; t < mepcs_pkg::TRACK_COUNT; t++) begin
            recent[t] = make_req(t[3:0], 1'b1, 8'h00, 4'h0, {8{7'h00}});
        end
        sent      = 0;
        calm_left = 0;
        while (sent < RANDOM_REQUESTS) begin
            trk  = $urandom_range(0, mepcs_pkg::TRACK_COUNT - 1);
            req  = recent[trk];
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                req = IN_W'({$urandom(), $urandom(), $urandom()});
                req.track_active = 1'b0;
            end else begin
                if (roll < 22) begin
                    req.out_port = ($urandom_range(0, 2) == 0)
                                   ? {mepcs_pkg::BUS_NIBBLE, 4'($urandom())}
                                   : 8'($urandom());
                    if ($urandom_range(0, 1) == 0) req.out_channel = 4'($urandom());
                end
                vals = {req.mode_value, req.shape_value, req.clock_value, req.color_value,
                        req.feedback_value, req.depth_value, req.rate_value, req.delay_value};
                for (int i = 0; i < mepcs_pkg::PARAM_COUNT; i++) begin
                    case ($urandom_range(0, 11)) inside
                        0:       vals[55 - 7 * i -: 7] = 7'h00;
                        1:       vals[55 - 7 * i -: 7] = 7'h7F;
                        [2:3]:   vals[55 - 7 * i -: 7] = 7'($urandom());
                        default: ;
                    endcase
                end
                req = make_req(trk[3:0], 1'b1, req.out_port, req.out_channel, vals);
                recent[trk] = req;
            end
            if (calm_left == 0 && $urandom_range(0, 19) == 0) calm_left = $urandom_range(8, 20);
            if (calm_left > 0) begin
                calm_left--;
                send_request(req, 0);
            end else begin
                send_request(req, pick_gap());
            end
            sent++;
        end
        s_valid <= 1'b0;

        while (board.pending_msgs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.pending_msgs.size() != 0)
            report_mismatch($sformatf("%0d messages never arrived", board.pending_msgs.size()));
        $display("Run covered %0d active and %0d inactive update requests, %0d messages checked",
                 active_seen, inactive_seen, msgs_checked);
        $display("of which %0d went to the internal bus and %0d were key pressure; %0d mismatches",
                 bus_msgs, pressure_msgs, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
